[rtl/tdf_pkg.sv]
`default_nettype none
package tdf_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAG_W       = 32;
    localparam int EXP_W       = 5;
    localparam int ROOT_W      = 16;
    localparam int DIV_CNT_W   = $clog2(MAG_W + 1);

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_PEND,
        EMIT_PEND_LAST,
        EMIT_TAIL,
        EMIT_EMPTY
    } t_emit;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  sq;
        logic  div_start;
        logic  div_take;
        logic  root_mul;
        logic  close;
        logic  next_c;
        logic  sf_mul_rem;
        t_emit emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mag_le1;
        logic sq_gt_rem;
        logic div_done;
        logic div_rem_zero;
        logic mult_even;
        logic mult_nz;
        logic rem_gt1;
        logic have_pend;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/trial_division_factorizer.sv]
// Each trial divisor goes through the control states and the bit-serial divider (tdf_div),
// and each extra division by a divisor that divides runs the divider again; up to about
// 23,200 divisors are tried for a 32-bit input.
// One request at a time; start is taken again once busy falls.
// Reset is synchronous and active low; results are strobed and cannot be stalled.
`default_nettype none
module trial_division_factorizer #(
    parameter int WIDTH = tdf_pkg::VALUE_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [WIDTH-1:0]           i_value,
    output logic                            o_valid,
    output logic [tdf_pkg::MAG_W-1:0]       o_prime,
    output logic [tdf_pkg::EXP_W-1:0]       o_exponent,
    output logic                            o_last,
    output logic                            o_empty_res,
    output logic [tdf_pkg::MAG_W-1:0]       o_squarefree_part,
    output logic [tdf_pkg::ROOT_W-1:0]      o_square_root_part,
    output logic                            o_cube_free
);
    import tdf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tdf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tdf_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_value            (i_value),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_valid            (o_valid),
        .o_prime            (o_prime),
        .o_exponent         (o_exponent),
        .o_last             (o_last),
        .o_empty_res        (o_empty_res),
        .o_squarefree_part  (o_squarefree_part),
        .o_square_root_part (o_square_root_part),
        .o_cube_free        (o_cube_free)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("non-final result while idle");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_last && o_prime == '0)
        else $error("empty result is not a lone final result");

    a_factor_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_empty_res |-> o_exponent != '0 && o_prime > 32'd1)
        else $error("factor result with bad prime or exponent");
`endif

endmodule
`default_nettype wire

[rtl/tdf_div.sv]
`default_nettype none
module tdf_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tdf_pkg::MAG_W-1:0]  i_dividend,
    input  wire logic [tdf_pkg::MAG_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [tdf_pkg::MAG_W-1:0]       o_quot,
    output logic [tdf_pkg::MAG_W-1:0]       o_rem
);
    import tdf_pkg::*;

    logic [MAG_W-1:0]     r_q;
    logic [MAG_W-1:0]     r_r;
    logic [MAG_W-1:0]     r_d;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_run;
    logic                 r_done;

    logic [MAG_W:0] n_shift;
    logic [MAG_W:0] n_diff;

    // Restoring division, one quotient bit per cycle.
    assign n_shift = {r_r, r_q[MAG_W-1]};
    assign n_diff  = n_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= DIV_CNT_W'(MAG_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_run) begin
            if (!n_diff[MAG_W]) begin
                r_r <= n_diff[MAG_W-1:0];
                r_q <= {r_q[MAG_W-2:0], 1'b1};
            end else begin
                r_r <= n_shift[MAG_W-1:0];
                r_q <= {r_q[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule
`default_nettype wire

[rtl/tdf_datapath.sv]
`default_nettype none
module tdf_datapath #(
    parameter int WIDTH = tdf_pkg::VALUE_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [WIDTH-1:0]           i_value,
    input  wire tdf_pkg::t_dp_cmd           i_cmd,
    output tdf_pkg::t_dp_sts                o_sts,
    output logic                            o_valid,
    output logic [tdf_pkg::MAG_W-1:0]       o_prime,
    output logic [tdf_pkg::EXP_W-1:0]       o_exponent,
    output logic                            o_last,
    output logic                            o_empty_res,
    output logic [tdf_pkg::MAG_W-1:0]       o_squarefree_part,
    output logic [tdf_pkg::ROOT_W-1:0]      o_square_root_part,
    output logic                            o_cube_free
);
    import tdf_pkg::*;

    localparam int EFF_W = (WIDTH > MAG_W) ? MAG_W : WIDTH;

    logic [MAG_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_cand;
    logic [EXP_W-1:0]  r_mult;
    logic [MAG_W-1:0]  r_sf;
    logic [ROOT_W-1:0] r_root;
    logic              r_cube;
    logic [2*MAG_W-1:0] r_sq;
    logic [MAG_W-1:0]  r_pend_p;
    logic [EXP_W-1:0]  r_pend_e;
    logic              r_have_pend;

    logic               r_valid;
    logic [MAG_W-1:0]   r_prime;
    logic [EXP_W-1:0]   r_exp;
    logic               r_last;
    logic               r_empty;
    logic [MAG_W-1:0]   r_sf_out;
    logic [ROOT_W-1:0]  r_root_out;
    logic               r_cube_out;

    logic [EFF_W-1:0]   n_val;
    logic [EFF_W-1:0]   n_mag_eff;
    logic [MAG_W-1:0]   n_mag;
    logic [2*MAG_W-1:0] n_sf_prod;
    logic [2*ROOT_W-1:0] n_root_prod;
    logic               div_done;
    logic [MAG_W-1:0]   div_quot;
    logic [MAG_W-1:0]   div_rem;

    // The most negative value negates to itself, which read unsigned is its magnitude.
    assign n_val     = i_value[EFF_W-1:0];
    assign n_mag_eff = n_val[EFF_W-1] ? (~n_val + 1'b1) : n_val;
    assign n_mag     = MAG_W'(n_mag_eff);

    assign n_sf_prod   = r_sf * (i_cmd.sf_mul_rem ? r_rem : r_cand);
    assign n_root_prod = r_root * r_cand[ROOT_W-1:0];

    tdf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rem),
        .i_divisor  (r_cand),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_have_pend <= 1'b0;
        end else if (i_cmd.close) begin
            r_have_pend <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= n_mag;
            r_cand <= MAG_W'(2);
            r_mult <= '0;
            r_sf   <= MAG_W'(1);
            r_root <= ROOT_W'(1);
            r_cube <= 1'b1;
        end else begin
            if (i_cmd.sq) begin
                r_sq <= r_cand * r_cand;
            end
            if (i_cmd.div_take) begin
                r_rem  <= div_quot;
                r_mult <= r_mult + 1'b1;
            end
            if (i_cmd.root_mul) begin
                r_root <= n_root_prod[ROOT_W-1:0];
            end
            if (i_cmd.close) begin
                r_pend_p <= r_cand;
                r_pend_e <= r_mult;
                r_mult   <= '0;
                if (r_mult > EXP_W'(2)) begin
                    r_cube <= 1'b0;
                end
                if (r_mult[0]) begin
                    r_sf <= n_sf_prod[MAG_W-1:0];
                end
            end
            if (i_cmd.sf_mul_rem) begin
                r_sf <= n_sf_prod[MAG_W-1:0];
            end
            if (i_cmd.next_c) begin
                r_cand <= (r_cand == MAG_W'(2)) ? MAG_W'(3) : r_cand + MAG_W'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.emit != EMIT_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit)
            EMIT_PEND: begin
                r_prime    <= r_pend_p;
                r_exp      <= r_pend_e;
                r_last     <= 1'b0;
                r_empty    <= 1'b0;
                r_sf_out   <= '0;
                r_root_out <= '0;
                r_cube_out <= 1'b0;
            end
            EMIT_PEND_LAST: begin
                r_prime    <= r_pend_p;
                r_exp      <= r_pend_e;
                r_last     <= 1'b1;
                r_empty    <= 1'b0;
                r_sf_out   <= r_sf;
                r_root_out <= r_root;
                r_cube_out <= r_cube;
            end
            EMIT_TAIL: begin
                r_prime    <= r_rem;
                r_exp      <= EXP_W'(1);
                r_last     <= 1'b1;
                r_empty    <= 1'b0;
                r_sf_out   <= r_sf;
                r_root_out <= r_root;
                r_cube_out <= r_cube;
            end
            EMIT_EMPTY: begin
                r_prime    <= '0;
                r_exp      <= '0;
                r_last     <= 1'b1;
                r_empty    <= 1'b1;
                r_sf_out   <= MAG_W'(1);
                r_root_out <= r_rem[ROOT_W-1:0];
                r_cube_out <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.mag_le1      = (r_rem <= MAG_W'(1));
        o_sts.sq_gt_rem    = (r_sq > (2*MAG_W)'(r_rem));
        o_sts.div_done     = div_done;
        o_sts.div_rem_zero = (div_rem == '0);
        o_sts.mult_even    = !r_mult[0];
        o_sts.mult_nz      = (r_mult != '0);
        o_sts.rem_gt1      = (r_rem > MAG_W'(1));
        o_sts.have_pend    = r_have_pend;
    end

    assign o_valid            = r_valid;
    assign o_prime            = r_prime;
    assign o_exponent         = r_exp;
    assign o_last             = r_last;
    assign o_empty_res        = r_empty;
    assign o_squarefree_part  = r_sf_out;
    assign o_square_root_part = r_root_out;
    assign o_cube_free        = r_cube_out;

endmodule
`default_nettype wire

[rtl/tdf_ctrl.sv]
`default_nettype none
module tdf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire tdf_pkg::t_dp_sts  i_sts,
    output tdf_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);
    import tdf_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_LOAD   = 9'b000000010,
        ST_SQ     = 9'b000000100,
        ST_CMP    = 9'b000001000,
        ST_DIV    = 9'b000010000,
        ST_TAKE   = 9'b000100000,
        ST_NEXT   = 9'b001000000,
        ST_FINISH = 9'b010000000,
        ST_TAIL   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.emit       = EMIT_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_sts.mag_le1) begin
                    o_cmd.emit = EMIT_EMPTY;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                if (i_sts.sq_gt_rem) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.div_rem_zero) begin
                        o_cmd.div_take = 1'b1;
                        n_state        = ST_TAKE;
                    end else begin
                        // A finished prime pushes out the one held before it.
                        if (i_sts.mult_nz) begin
                            o_cmd.close = 1'b1;
                            o_cmd.emit  = i_sts.have_pend ? EMIT_PEND : EMIT_NONE;
                        end
                        n_state = ST_NEXT;
                    end
                end
            end
            ST_TAKE: begin
                o_cmd.root_mul  = i_sts.mult_even;
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_NEXT: begin
                o_cmd.next_c = 1'b1;
                n_state      = ST_SQ;
            end
            ST_FINISH: begin
                if (i_sts.rem_gt1) begin
                    o_cmd.emit       = i_sts.have_pend ? EMIT_PEND : EMIT_NONE;
                    o_cmd.sf_mul_rem = 1'b1;
                    n_state          = ST_TAIL;
                end else begin
                    o_cmd.emit = EMIT_PEND_LAST;
                    n_state    = ST_IDLE;
                end
            end
            ST_TAIL: begin
                o_cmd.emit = EMIT_TAIL;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

[dv/tb_trial_division_factorizer.sv]
`timescale 1ns / 1ps
module tb_trial_division_factorizer;
    import tdf_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0]  prime;
        logic [EXP_W-1:0]  exponent;
        logic              last;
        logic              empty_res;
        logic [MAG_W-1:0]  squarefree;
        logic [ROOT_W-1:0] root;
        logic              cube_free;
    } t_factor;

    class factor_scoreboard;
        t_factor     expected_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // Factors the magnitude of an accepted request and queues the factors it should give.
        function void note_request(logic [31:0] v);
            longint unsigned mag;
            longint unsigned rem;
            longint unsigned cand;
            longint unsigned sf;
            longint unsigned root;
            longint unsigned primes[9];
            int unsigned     exps[9];
            int unsigned     mult;
            int              n;
            bit              cube;
            t_factor         f;

            mag  = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
            rem  = mag;
            cand = 2;
            sf   = 1;
            root = 1;
            cube = 1'b1;
            n    = 0;
            if (mag <= 1) begin
                f.prime      = '0;
                f.exponent   = '0;
                f.last       = 1'b1;
                f.empty_res  = 1'b1;
                f.squarefree = 1;
                f.root       = ROOT_W'(mag);
                f.cube_free  = 1'b1;
                expected_q.push_back(f);
                return;
            end
            while (cand * cand <= rem && n < 9) begin
                mult = 0;
                while (rem % cand == 0) begin
                    rem = rem / cand;
                    mult++;
                end
                if (mult != 0) begin
                    primes[n] = cand;
                    exps[n]   = mult;
                    n++;
                    if (mult[0])
                        sf = sf * cand;
                    for (int i = 0; i < mult / 2; i++)
                        root = root * cand;
                    if (mult > 2)
                        cube = 1'b0;
                end
                if (rem == 1)
                    break;
                cand = (cand == 2) ? 3 : cand + 2;
            end
            // Whatever is left above one after the scan is itself prime.
            if (rem > 1 && n < 9) begin
                primes[n] = rem;
                exps[n]   = 1;
                n++;
                sf = sf * rem;
            end
            for (int k = 0; k < n; k++) begin
                f.prime      = MAG_W'(primes[k]);
                f.exponent   = EXP_W'(exps[k]);
                f.last       = (k == n - 1);
                f.empty_res  = 1'b0;
                f.squarefree = f.last ? MAG_W'(sf) : '0;
                f.root       = f.last ? ROOT_W'(root) : '0;
                f.cube_free  = f.last ? cube : 1'b0;
                expected_q.push_back(f);
            end
        endfunction

        function void compare_field(string name, longint unsigned exp_v, logic [63:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_factor(t_factor got);
            t_factor exp_f;

            if (expected_q.size() == 0) begin
                $error("factor result with no request outstanding: prime %0d exponent %0d",
                       got.prime, got.exponent);
                errors++;
                return;
            end
            exp_f = expected_q.pop_front();
            compare_field("prime", exp_f.prime, got.prime);
            compare_field("exponent", exp_f.exponent, got.exponent);
            compare_field("last", exp_f.last, got.last);
            compare_field("empty_res", exp_f.empty_res, got.empty_res);
            compare_field("squarefree_part", exp_f.squarefree, got.squarefree);
            compare_field("square_root_part", exp_f.root, got.root);
            compare_field("cube_free", exp_f.cube_free, got.cube_free);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [31:0]       i_value;
    logic              o_valid;
    logic [MAG_W-1:0]  o_prime;
    logic [EXP_W-1:0]  o_exponent;
    logic              o_last;
    logic              o_empty_res;
    logic [MAG_W-1:0]  o_squarefree_part;
    logic [ROOT_W-1:0] o_square_root_part;
    logic              o_cube_free;

    factor_scoreboard sb;

    trial_division_factorizer i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_value            (i_value),
        .o_valid            (o_valid),
        .o_prime            (o_prime),
        .o_exponent         (o_exponent),
        .o_last             (o_last),
        .o_empty_res        (o_empty_res),
        .o_squarefree_part  (o_squarefree_part),
        .o_square_root_part (o_square_root_part),
        .o_cube_free        (o_cube_free)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_factor({o_prime, o_exponent, o_last, o_empty_res,
                             o_squarefree_part, o_square_root_part, o_cube_free});
    end

    // Holds the request until it is taken, after an optional idle burst.
    task automatic send_request(input logic [31:0] v, input bit allow_gap);
        if (allow_gap && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        do
            @(posedge i_clk);
        while (busy);
        sb.note_request(v);
    endtask

    initial begin
        logic [31:0]     directed[];
        longint unsigned mag;
        longint unsigned factor;
        int              big_left;

        sb       = new();
        start    = 1'b0;
        i_value  = '0;
        i_rst_n  = 1'b0;
        big_left = 2;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE, 32'd3, 32'd4, 32'd8,
                     32'd12, 32'd36, 32'd49, 32'd1000, 32'd9409, 32'd223092870,
                     -32'sd223092870, 32'h4000_0000, 32'd1162261467, 32'd1070596096,
                     32'h5555_5555, 32'hAAAA_AAAB, 32'h8000_0000, 32'h7FFF_FFFF};
        foreach (directed[i])
            send_request(directed[i], 1'b1);

        for (int i = 0; i < 78; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                mag = $urandom_range(0, 15);
            end else if (big_left > 0 && $urandom_range(0, 99) < 3) begin
                // A large cofactor makes the scan long, so only a couple are allowed.
                big_left--;
                mag = $urandom_range(2, 1 << 20);
            end else begin
                mag = 1;
                repeat ($urandom_range(1, 14)) begin
                    factor = ($urandom_range(0, 9) < 3) ? $urandom_range(2, 3)
                                                        : $urandom_range(2, 100);
                    if (mag * factor < 64'h8000_0000)
                        mag = mag * factor;
                end
                if ($urandom_range(0, 9) < 3) begin
                    factor = $urandom_range(2, 4095);
                    if (mag * factor < 64'h8000_0000)
                        mag = mag * factor;
                end
            end
            if ($urandom_range(0, 1) == 1)
                send_request(32'(64'h1_0000_0000 - mag), i < 62);
            else
                send_request(32'(mag), i < 62);
        end
        start <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_trial_division_factorizer: clean");
        else
            $display("tb_trial_division_factorizer: errors");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb_trial_division_factorizer: errors");
        $finish;
    end

endmodule
